### sv/afc53_pkg.sv
// shared types, constants and lookup functions for the 53-symbol affine cipher
// no dependencies
package afc53_pkg;

  // alphabet size and reciprocal for the modulo reduction
  localparam int SymCount   = 53;
  localparam int SymW       = 6;
  localparam int ProdW      = 12;
  localparam int RecipShift = 16;
  localparam logic [10:0] RECIP = 11'd1236;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_KEY_MULT     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_ADD      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DECRYPT_MODE = 2'd2;

  localparam logic [SymW-1:0] SYM_MAX   = 6'd53;
  localparam logic [SymW-1:0] SYM_SPACE = 6'd26;
  localparam logic [SymW-1:0] SYM_UPPER = 6'd27;

  // multiplicative inverses modulo 53, entry 0 has none
  localparam logic [SymW-1:0] INV_TABLE [0:63] = '{
    6'd0,  6'd1,  6'd27, 6'd18, 6'd40, 6'd32, 6'd9,  6'd38,
    6'd20, 6'd6,  6'd16, 6'd29, 6'd31, 6'd49, 6'd19, 6'd46,
    6'd10, 6'd25, 6'd3,  6'd14, 6'd8,  6'd48, 6'd41, 6'd30,
    6'd42, 6'd17, 6'd51, 6'd2,  6'd36, 6'd11, 6'd23, 6'd12,
    6'd5,  6'd45, 6'd39, 6'd50, 6'd28, 6'd43, 6'd7,  6'd34,
    6'd4,  6'd22, 6'd24, 6'd37, 6'd47, 6'd33, 6'd15, 6'd44,
    6'd21, 6'd13, 6'd35, 6'd26, 6'd52, 6'd0,  6'd0,  6'd0,
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
  };

  // sideband that travels with each byte
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       sym;
    logic       bad;
  } afc53_side_t;

  // operands of the multiply-add
  typedef struct packed {
    logic [SymW-1:0] mult;
    logic [SymW-1:0] idx;
    logic [SymW-1:0] offs;
  } afc53_op_t;

  // reduce a 6-bit key modulo 53
  function automatic logic [SymW-1:0] key_reduce(input logic [SymW-1:0] k);
    key_reduce = (k >= SYM_MAX) ? k - SYM_MAX : k;
  endfunction

  // alphabet index of a byte
  function automatic logic [SymW-1:0] sym_index(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h61 && c <= 8'h7a) t = c - 8'h61;
    else if (c == 8'h20) t = {2'b00, SYM_SPACE};
    else if (c >= 8'h41 && c <= 8'h5a) t = c - 8'h41 + {2'b00, SYM_UPPER};
    sym_index = t[SymW-1:0];
  endfunction

  // byte is an alphabet symbol
  function automatic logic sym_valid(input logic [7:0] c);
    sym_valid = (c >= 8'h61 && c <= 8'h7a) || (c == 8'h20) ||
                (c >= 8'h41 && c <= 8'h5a);
  endfunction

  // byte for an alphabet index
  function automatic logic [7:0] sym_char(input logic [SymW-1:0] k);
    if (k < SYM_SPACE) sym_char = 8'h61 + {2'b00, k};
    else if (k == SYM_SPACE) sym_char = 8'h20;
    else sym_char = 8'h41 + {2'b00, k} - {2'b00, SYM_UPPER};
  endfunction

endpackage

### sv/afc53_front.sv
// front stages: symbol decode, key reduction and operand selection
// depends on afc53_pkg
module afc53_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [7:0]               char_in,
  input  logic                     is_last,
  input  logic [5:0]               key_mult,
  input  logic [5:0]               key_add,
  input  logic                     decrypt_mode,
  output logic                     op_valid,
  output afc53_pkg::afc53_op_t     op,
  output afc53_pkg::afc53_side_t   side
);
  import afc53_pkg::*;

  logic              s1_valid;
  afc53_side_t       s1_side;
  logic [SymW-1:0]   s1_idx;
  logic [SymW-1:0]   s1_a;
  logic [SymW-1:0]   s1_b;
  logic              s1_dec;

  logic [SymW-1:0]   a_red;
  logic [SymW:0]     diff;
  logic [SymW-1:0]   diff_red;

  assign a_red = key_reduce(key_mult);

  // stage 1: decode byte, reduce keys
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_side.ch   <= char_in;
    s1_side.last <= is_last;
    s1_side.sym  <= sym_valid(char_in);
    s1_side.bad  <= (a_red == '0);
    s1_idx       <= sym_index(char_in);
    s1_a         <= a_red;
    s1_b         <= key_reduce(key_add);
    s1_dec       <= decrypt_mode;
  end

  // (j - b) mod 53 for decryption
  assign diff     = {1'b0, s1_idx} + {1'b0, SYM_MAX} - {1'b0, s1_b};
  assign diff_red = (diff >= {1'b0, SYM_MAX}) ? diff[SymW-1:0] - SYM_MAX : diff[SymW-1:0];

  // stage 2: pick multiplier, index and offset for the mode
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= s1_valid;
    end
    side <= s1_side;
    if (s1_dec) begin
      op.mult <= INV_TABLE[s1_a];
      op.idx  <= diff_red;
      op.offs <= '0;
    end else begin
      op.mult <= s1_a;
      op.idx  <= s1_idx;
      op.offs <= s1_b;
    end
  end

endmodule

### sv/afc53_mulmod.sv
// back stages: multiply-add, modulo 53 by reciprocal, symbol lookup
// depends on afc53_pkg
module afc53_mulmod (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     op_valid,
  input  afc53_pkg::afc53_op_t     op,
  input  afc53_pkg::afc53_side_t   side,
  output logic                     done,
  output logic [7:0]               char_out,
  output logic                     last_out,
  output logic                     in_alphabet,
  output logic                     key_invalid
);
  import afc53_pkg::*;

  logic              v3, v4;
  afc53_side_t       side3, side4;
  logic [ProdW-1:0]  p3, p4;
  logic [SymW-1:0]   q4;
  logic [22:0]       qprod;
  logic [ProdW-1:0]  qm;
  logic [ProdW-1:0]  rem_raw;
  logic [SymW:0]     rem7;
  logic [SymW-1:0]   k;

  // stage 3: m*j + offset
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= op_valid;
    end
    side3 <= side;
    p3    <= {{(ProdW-SymW){1'b0}}, op.mult} * {{(ProdW-SymW){1'b0}}, op.idx} +
             {{(ProdW-SymW){1'b0}}, op.offs};
  end

  // stage 4: quotient estimate, low by at most one
  assign qprod = {11'd0, p3} * {12'd0, RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    side4 <= side3;
    p4    <= p3;
    q4    <= qprod[RecipShift +: SymW];
  end

  // remainder with one correction step
  assign qm      = {{(ProdW-SymW){1'b0}}, q4} * {{(ProdW-SymW){1'b0}}, SYM_MAX};
  assign rem_raw = p4 - qm;
  assign rem7    = rem_raw[SymW:0];
  assign k       = (rem7 >= {1'b0, SYM_MAX}) ? rem7[SymW-1:0] - SYM_MAX : rem7[SymW-1:0];

  // stage 5: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    char_out    <= (side4.sym && !side4.bad) ? sym_char(k) : side4.ch;
    last_out    <= side4.last;
    in_alphabet <= side4.sym;
    key_invalid <= side4.bad;
  end

endmodule

### sv/affine_cipher_53_symbol_unit.sv
// affine cipher over a 53-symbol alphabet, top level with key registers
// throughput: one byte every cycle
// the five pipeline registers lie between start and done; busy stays low, results are not held
// synchronous reset clears valid bits and sets keys to a=1, b=0, encrypt
// depends on afc53_pkg, afc53_front, afc53_mulmod
module affine_cipher_53_symbol_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        char_in,
  input  logic                              is_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [afc53_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [5:0]                        cfg_data,
  output logic                              done,
  output logic [7:0]                        char_out,
  output logic                              last_out,
  output logic                              in_alphabet,
  output logic                              key_invalid
);
  import afc53_pkg::*;

  logic [5:0]   key_mult;
  logic [5:0]   key_add;
  logic         decrypt_mode;
  logic         op_valid;
  afc53_op_t    op;
  afc53_side_t  side;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // key registers, written on a config transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mult     <= 6'd1;
      key_add      <= 6'd0;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_MULT:     key_mult     <= cfg_data;
        REG_KEY_ADD:      key_add      <= cfg_data;
        REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // decode and operand stages
  afc53_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .char_in      (char_in),
    .is_last      (is_last),
    .key_mult     (key_mult),
    .key_add      (key_add),
    .decrypt_mode (decrypt_mode),
    .op_valid     (op_valid),
    .op           (op),
    .side         (side)
  );

  // arithmetic and result stages
  afc53_mulmod u_mulmod (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (op_valid),
    .op          (op),
    .side        (side),
    .done        (done),
    .char_out    (char_out),
    .last_out    (last_out),
    .in_alphabet (in_alphabet),
    .key_invalid (key_invalid)
  );

endmodule
